[rtl/arcade_mix_dual_pid_velocity_macros.svh]
// Assertion macros shared by the RTL of the drive velocity controller.
`ifndef ARCADE_MIX_DUAL_PID_VELOCITY_MACROS_SVH
`define ARCADE_MIX_DUAL_PID_VELOCITY_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define AMDPV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define AMDPV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/amdpv_pkg.sv]
// Package: types, widths and register codes of the drive velocity controller.
`default_nettype none
package amdpv_pkg;

  localparam int SUM_WIDTH = 24;
  localparam int CMD_W     = 8;
  localparam int GAIN_W    = 16;
  localparam int DZ_W      = 10;
  localparam int SCALE_W   = 4;
  localparam int SCL_W     = CMD_W + SCALE_W;
  localparam int TGT_W     = SCL_W + 1;
  localparam int ERR_W     = TGT_W;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int P_W       = GAIN_W + 1 + ERR_W;
  localparam int I_W       = GAIN_W + 1 + SUM_WIDTH;
  localparam int D_W       = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W     = I_W + 2;
  localparam int DRIVE_W   = 20;
  localparam int FRAC_SH   = 6;
  localparam int ROUND_C   = 1 << (FRAC_SH - 1);
  localparam int Q_W       = ACC_W - FRAC_SH;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_KP    = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI    = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD    = 3'd2;
  localparam logic [IDX_W-1:0] REG_DZ    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCALE = 3'd4;

  localparam logic [GAIN_W-1:0]  KP_RST    = 16'd4915;
  localparam logic [GAIN_W-1:0]  KI_RST    = 16'd0;
  localparam logic [GAIN_W-1:0]  KD_RST    = 16'd819;
  localparam logic [DZ_W-1:0]    DZ_RST    = 10'd5;
  localparam logic [SCALE_W-1:0] SCALE_RST = 4'd3;

  typedef struct packed {
    logic signed [CMD_W-1:0] forward_cmd;
    logic signed [CMD_W-1:0] turn_cmd;
    logic signed [CMD_W-1:0] left_measured;
    logic signed [CMD_W-1:0] right_measured;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      stop_request;
  } out_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gains_t;

  typedef struct packed {
    logic load_err;
    logic load_prod;
    logic load_sum;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [TGT_W-1:0] left_target;
    logic signed [TGT_W-1:0] right_target;
    logic                    stop;
  } mix_res_t;

endpackage
`default_nettype wire

[rtl/arcade_mix_dual_pid_velocity.sv]
// Top level: drive velocity controller with arcade mixing and two PID lanes.
//
// Input channel in_valid/in_ready/in_data carries one control tick: forward
// and turn commands plus measured left and right speeds. Output channel
// out_valid/out_ready/out_data carries the left and right drive (signed Q.8
// percent, saturated) and the stop flag. One result per tick.
// Gains, deadband and command scale sit on an APB port, one 32-bit register
// per word; write only while no tick is in flight.
// A tick steps the sequencer through mix, error/integral, products, sum
// and output; a new tick is taken only once the last one has left the
// output step. The two lanes run side by side and the output register
// merges their results.
// If the receiver stalls, the finished tick waits in the output step until
// the output register is free, and no new tick is taken meanwhile.
// Reset clears the sequencer, both integrals and previous errors, the
// output valid, and loads the register defaults.
`default_nettype none
module arcade_mix_dual_pid_velocity (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire amdpv_pkg::in_item_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output amdpv_pkg::out_item_t                 out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [amdpv_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [amdpv_pkg::DATA_W-1:0]    pwdata,
  output logic [amdpv_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);
  import amdpv_pkg::*;
  `include "arcade_mix_dual_pid_velocity_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERR  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  gains_t              gains_r;
  logic [DZ_W-1:0]     dz_r;
  logic [SCALE_W-1:0]  scale_r;
  logic                cfg_wr;
  logic [IDX_W-1:0]    cfg_idx;
  logic                in_xfer;
  logic                out_load;
  logic                out_valid_r;
  logic                out_valid_nxt;
  out_item_t           out_data_r;
  lane_ctl_t           lane_ctl;
  mix_res_t            mix_q;
  logic signed [CMD_W-1:0]   left_meas_r;
  logic signed [CMD_W-1:0]   right_meas_r;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.kp <= KP_RST;
      gains_r.ki <= KI_RST;
      gains_r.kd <= KD_RST;
      dz_r       <= DZ_RST;
      scale_r    <= SCALE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KP:    gains_r.kp <= pwdata[GAIN_W-1:0];
        REG_KI:    gains_r.ki <= pwdata[GAIN_W-1:0];
        REG_KD:    gains_r.kd <= pwdata[GAIN_W-1:0];
        REG_DZ:    dz_r       <= pwdata[DZ_W-1:0];
        REG_SCALE: scale_r    <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KP:    prdata = DATA_W'(gains_r.kp);
      REG_KI:    prdata = DATA_W'(gains_r.ki);
      REG_KD:    prdata = DATA_W'(gains_r.kd);
      REG_DZ:    prdata = DATA_W'(dz_r);
      REG_SCALE: prdata = DATA_W'(scale_r);
      default:   prdata = '0;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lane_ctl.load_err  = (state_r == ST_ERR);
    lane_ctl.load_prod = (state_r == ST_MUL);
    lane_ctl.load_sum  = (state_r == ST_ADD);
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      left_meas_r  <= in_data.left_measured;
      right_meas_r <= in_data.right_measured;
    end
  end

  amdpv_mix u_mix (
    .clk           (clk),
    .load          (in_xfer),
    .item          (in_data),
    .dead_zone     (dz_r),
    .command_scale (scale_r),
    .res           (mix_q)
  );

  amdpv_lane u_lane_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lane_ctl),
    .gains    (gains_r),
    .target   (mix_q.left_target),
    .measured (left_meas_r),
    .drive    (left_drive)
  );

  amdpv_lane u_lane_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (lane_ctl),
    .gains    (gains_r),
    .target   (mix_q.right_target),
    .measured (right_meas_r),
    .drive    (right_drive)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.left_drive   <= left_drive;
      out_data_r.right_drive  <= right_drive;
      out_data_r.stop_request <= mix_q.stop;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `AMDPV_ASSERT_NEXT(a_accept_starts, in_xfer, state_r == ST_ERR, "tick transfer did not start lanes")
  `AMDPV_ASSERT_NOW(a_rise_from_out, $rose(out_valid_r), $past(state_r) == ST_OUT, "result without sequencer output step")
  `AMDPV_ASSERT_NOW(a_stop_targets, (state_r != ST_IDLE) && mix_q.stop, (mix_q.left_target == '0) && (mix_q.right_target == '0), "stop flag with nonzero target")
  `AMDPV_ASSERT_NEXT(a_stall_holds, (state_r == ST_OUT) && out_valid_r && !out_ready, (state_r == ST_OUT) && out_valid_r, "finished tick lost under stall")

endmodule
`default_nettype wire

[rtl/amdpv_mix.sv]
// Command scaling, deadband and arcade mixing into left and right targets.
`default_nettype none
module amdpv_mix (
  input  wire logic                            clk,
  input  wire logic                            load,
  input  wire amdpv_pkg::in_item_t             item,
  input  wire logic [amdpv_pkg::DZ_W-1:0]      dead_zone,
  input  wire logic [amdpv_pkg::SCALE_W-1:0]   command_scale,
  output amdpv_pkg::mix_res_t                  res
);
  import amdpv_pkg::*;

  logic signed [SCALE_W:0]  scale_s;
  logic signed [SCL_W-1:0]  fwd;
  logic signed [SCL_W-1:0]  trn;
  logic        [SCL_W-1:0]  fwd_mag;
  logic        [SCL_W-1:0]  trn_mag;
  logic        [SCL_W-1:0]  dz_ext;
  logic                     in_band;
  logic signed [SCL_W-1:0]  fwd_d;
  logic signed [SCL_W-1:0]  trn_d;
  mix_res_t                 res_r;
  mix_res_t                 res_nxt;

  always_comb begin
    scale_s = {1'b0, command_scale};
    fwd     = SCL_W'(item.forward_cmd * scale_s);
    trn     = SCL_W'(item.turn_cmd * scale_s);
    fwd_mag = fwd[SCL_W-1] ? SCL_W'(-fwd) : SCL_W'(fwd);
    trn_mag = trn[SCL_W-1] ? SCL_W'(-trn) : SCL_W'(trn);
    dz_ext  = SCL_W'(dead_zone);
    in_band = (fwd_mag < dz_ext) && (trn_mag < dz_ext);
    fwd_d   = in_band ? '0 : fwd;
    trn_d   = in_band ? '0 : trn;
    res_nxt.left_target  = TGT_W'(fwd_d) + TGT_W'(trn_d);
    res_nxt.right_target = TGT_W'(fwd_d) - TGT_W'(trn_d);
    res_nxt.stop         = (fwd_d == '0) && (trn_d == '0);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

[rtl/amdpv_lane.sv]
// One PID lane: error, saturating integral, three gain products, rounding.
`default_nettype none
module amdpv_lane (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire amdpv_pkg::lane_ctl_t                ctl,
  input  wire amdpv_pkg::gains_t                   gains,
  input  wire logic signed [amdpv_pkg::TGT_W-1:0]  target,
  input  wire logic signed [amdpv_pkg::CMD_W-1:0]  measured,
  output logic signed [amdpv_pkg::DRIVE_W-1:0]     drive
);
  import amdpv_pkg::*;

  logic signed [ERR_W-1:0]     err;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_sat;

  logic signed [ERR_W-1:0]     last_r;
  logic signed [SUM_WIDTH-1:0] integ_r;
  logic signed [ERR_W-1:0]     err_r;
  logic signed [DIFF_W-1:0]    diff_r;

  logic signed [GAIN_W:0]      kp_s;
  logic signed [GAIN_W:0]      ki_s;
  logic signed [GAIN_W:0]      kd_s;
  logic signed [P_W-1:0]       p_nxt;
  logic signed [I_W-1:0]       i_nxt;
  logic signed [D_W-1:0]       d_nxt;
  logic signed [P_W-1:0]       p_r;
  logic signed [I_W-1:0]       i_r;
  logic signed [D_W-1:0]       d_r;

  logic signed [ACC_W-1:0]     sum_nxt;
  logic signed [ACC_W-1:0]     sum_r;
  logic signed [Q_W-1:0]       q;
  logic                        q_fits;

  always_comb begin
    err      = ERR_W'(target) - ERR_W'(measured);
    sum_wide = (SUM_WIDTH+1)'(integ_r) + (SUM_WIDTH+1)'(err);
    if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
      sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      integ_r <= '0;
    end else if (ctl.load_err) begin
      last_r  <= err;
      integ_r <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_err) begin
      err_r  <= err;
      diff_r <= DIFF_W'(err) - DIFF_W'(last_r);
    end
  end

  always_comb begin
    kp_s  = {1'b0, gains.kp};
    ki_s  = {1'b0, gains.ki};
    kd_s  = {1'b0, gains.kd};
    p_nxt = kp_s * err_r;
    i_nxt = ki_s * integ_r;
    d_nxt = kd_s * diff_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      p_r <= p_nxt;
      i_r <= i_nxt;
      d_r <= d_nxt;
    end
  end

  assign sum_nxt = ACC_W'(p_r) + ACC_W'(i_r) + ACC_W'(d_r) + ACC_W'(ROUND_C);

  always_ff @(posedge clk) begin
    if (ctl.load_sum) begin
      sum_r <= sum_nxt;
    end
  end

  // floor shift to Q.8, then clamp to the drive range
  always_comb begin
    q      = sum_r[ACC_W-1:FRAC_SH];
    q_fits = (&q[Q_W-1:DRIVE_W-1]) || !(|q[Q_W-1:DRIVE_W-1]);
    if (q_fits) begin
      drive = q[DRIVE_W-1:0];
    end else begin
      drive = q[Q_W-1] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

endmodule
`default_nettype wire
